>>> hdl/plag_pkg.sv
// Package for the PIN attempt lockout gate: field widths, command and verdict
// codes, register map and the structs passed between the front, queue and back.
// No dependencies.
`default_nettype none

package plag_pkg;

    // Field widths
    localparam int PinDigits = 4;
    localparam int NumChars  = 5;
    localparam int CharW     = 8;
    localparam int NowW      = 32;
    localparam int PinW      = 14;
    localparam int IdleW     = 16;
    localparam int FailW     = 8;
    localparam int WinW      = 31;
    localparam int BudgetMsW = 26;

    // Arithmetic constants
    localparam int MsPerS  = 1000;
    localparam int DecBase = 10;
    localparam logic [CharW-1:0] CharZero = 8'h30;
    localparam logic [CharW-1:0] CharNine = 8'h39;
    localparam logic [CharW-1:0] CharNul  = 8'h00;

    // Stream layout
    localparam int InDataW  = 80;
    localparam int OutDataW = 48;
    localparam int CmdW     = 2;
    localparam int CharBase = NowW + 1;

    // Queue between front and back
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Configuration port
    localparam int AddrW  = 5;
    localparam int ApbW   = 32;

    typedef enum logic [CmdW-1:0] {
        CMD_OPEN   = 2'd0,
        CMD_CLOSE  = 2'd1,
        CMD_VERIFY = 2'd2,
        CMD_POLL   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        V_NONE   = 3'd0,
        V_OK     = 3'd1,
        V_NO_PIN = 3'd2,
        V_LOCKED = 3'd3,
        V_BAD    = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        REG_PIN_CODE       = 3'd0,
        REG_IDLE_REQUEST   = 3'd1,
        REG_IDLE_DEFAULT   = 3'd2,
        REG_IDLE_MAX       = 3'd3,
        REG_RESTORED_FAILS = 3'd4,
        REG_FAIL_LIMIT     = 3'd5,
        REG_LOCK_WINDOW    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [PinW-1:0]  pin_code;
        logic [IdleW-1:0] idle_request_s;
        logic [IdleW-1:0] idle_default_s;
        logic [IdleW-1:0] idle_max_s;
        logic [FailW-1:0] restored_fails;
        logic [FailW-1:0] fail_limit;
        logic [WinW-1:0]  lock_window_ms;
    } cfg_t;

    // Classified command as held in the queue
    typedef struct packed {
        cmd_t             cmd;
        logic [NowW-1:0]  now_ms;
        logic             attempt_ok;
        logic [PinW-1:0]  attempt_val;
    } q_item_t;

    // Result, first member in the highest bits so that it packs onto tdata
    typedef struct packed {
        logic             gate_is_open;
        logic [FailW-1:0] persist_fails;
        logic             idle_expired;
        logic [WinW-1:0]  lock_left_ms;
        verdict_t         verdict;
    } result_t;

    localparam int ResultW = $bits(result_t);

endpackage

`default_nettype wire

>>> hdl/plag_front.sv
// Front part of the PIN gate: accepts input beats and parses the attempt
// string into a digit value and a valid flag. Depends on plag_pkg.
`default_nettype none

module plag_front
    import plag_pkg::*;
(
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [InDataW-1:0] s_tdata,
    input  wire logic [CmdW-1:0]    s_tuser,
    input  wire logic               q_full,
    output logic                    q_push,
    output q_item_t                 q_item
);

    logic [CharW-1:0] chars [NumChars];
    logic             parse_ok;
    logic [PinW-1:0]  parse_val;

    // Take the characters apart from the beat
    always_comb
    begin
        for (int k = 0; k < NumChars; k++)
        begin
            chars[k] = s_tdata[CharBase + k*CharW +: CharW];
        end
    end

    // Check the digits and the trailing NUL, accumulate the value
    always_comb
    begin
        logic [CharW-1:0] digit;
        parse_ok  = s_tdata[NowW];
        parse_val = '0;
        digit     = '0;
        for (int k = 0; k < PinDigits; k++)
        begin
            if (!(chars[k] inside {[CharZero:CharNine]}))
            begin
                parse_ok = 1'b0;
            end
            digit     = chars[k] - CharZero;
            parse_val = PinW'(parse_val * DecBase) + PinW'(digit);
        end
        if (chars[PinDigits] != CharNul)
        begin
            parse_ok = 1'b0;
        end
    end

    // Hand the classified beat to the queue
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_item.cmd         = cmd_t'(s_tuser);
        q_item.now_ms      = s_tdata[NowW-1:0];
        q_item.attempt_ok  = parse_ok;
        q_item.attempt_val = parse_val;
    end

endmodule

`default_nettype wire

>>> hdl/plag_queue.sv
// Short queue of classified commands between the front and back parts.
// Depends on plag_pkg.
`default_nettype none

module plag_queue
    import plag_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire q_item_t item_in,
    output logic         full,
    input  wire logic    pop,
    output logic         empty,
    output q_item_t      item_out
);

    q_item_t          slot_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == QCntW'(QDepth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QDepth-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QDepth-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

>>> hdl/plag_back.sv
// Back part of the PIN gate: holds the gate state, carries out open, close,
// verify and poll, and registers the result beat. Depends on plag_pkg.
`default_nettype none

module plag_back
    import plag_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                q_empty,
    input  wire q_item_t             q_item,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OutDataW-1:0]      m_tdata
);

    // Gate state
    logic                 gate_open_reg, gate_open_next;
    logic [PinW-1:0]      held_pin_reg, held_pin_next;
    logic [BudgetMsW-1:0] idle_ms_reg, idle_ms_next;
    logic [FailW-1:0]     miss_cnt_reg, miss_cnt_next;
    logic                 lock_on_reg, lock_on_next;
    logic [NowW-1:0]      deadline_reg, deadline_next;
    logic [NowW-1:0]      last_ok_reg, last_ok_next;

    // Output stage
    logic                 out_valid_reg;
    result_t              out_data_reg, out_data_next;

    logic                 step;
    logic [NowW-1:0]      now;
    logic [NowW-1:0]      lock_diff;
    logic [WinW-1:0]      old_left;
    logic [NowW-1:0]      idle_diff;
    logic                 idle_old;
    logic [IdleW-1:0]     idle_sel;
    logic [FailW-1:0]     fail_inc;

    assign step  = !q_empty && (!out_valid_reg || m_tready);
    assign q_pop = step;
    assign now   = q_item.now_ms;

    // Lock time left and idle check against the state before the command
    assign lock_diff = deadline_reg - now;
    assign old_left  = (lock_on_reg && lock_diff != '0
                        && lock_diff <= NowW'(cfg.lock_window_ms))
                       ? lock_diff[WinW-1:0] : '0;
    assign idle_diff = now - last_ok_reg;
    assign idle_old  = (idle_diff >= NowW'(idle_ms_reg));

    // Clamp the idle budget requested at open, or take the default when none is requested
    always_comb
    begin
        if (cfg.idle_request_s == '0)
        begin
            idle_sel = cfg.idle_default_s;
        end
        else if (cfg.idle_request_s > cfg.idle_max_s)
        begin
            idle_sel = cfg.idle_max_s;
        end
        else
        begin
            idle_sel = cfg.idle_request_s;
        end
    end

    assign fail_inc = (miss_cnt_reg < cfg.fail_limit) ? miss_cnt_reg + 1'b1
                                                      : miss_cnt_reg;

    // Carry out the command and build the result
    always_comb
    begin
        logic rearm;
        logic touch;
        logic fresh_zero;
        gate_open_next  = gate_open_reg;
        held_pin_next   = held_pin_reg;
        idle_ms_next    = idle_ms_reg;
        miss_cnt_next   = miss_cnt_reg;
        lock_on_next    = lock_on_reg;
        deadline_next   = deadline_reg;
        last_ok_next    = last_ok_reg;
        rearm           = 1'b0;
        touch           = 1'b0;
        fresh_zero      = 1'b0;
        out_data_next.verdict = V_NONE;

        case (q_item.cmd)
            CMD_OPEN:
            begin
                last_ok_next    = now;
                deadline_next   = now;
                held_pin_next   = cfg.pin_code;
                idle_ms_next    = BudgetMsW'(idle_sel) * BudgetMsW'(MsPerS);
                miss_cnt_next   = (cfg.restored_fails > cfg.fail_limit)
                                  ? cfg.fail_limit : cfg.restored_fails;
                lock_on_next    = 1'b0;
                gate_open_next  = 1'b1;
                touch           = 1'b1;
                fresh_zero      = (idle_sel == '0);
            end
            CMD_CLOSE:
            begin
                gate_open_next = 1'b0;
            end
            CMD_VERIFY:
            begin
                if (!gate_open_reg || held_pin_reg == '0)
                begin
                    out_data_next.verdict = V_NO_PIN;
                end
                else if (old_left != '0)
                begin
                    out_data_next.verdict = V_LOCKED;
                end
                else if (!q_item.attempt_ok || q_item.attempt_val != held_pin_reg)
                begin
                    out_data_next.verdict = V_BAD;
                    miss_cnt_next         = fail_inc;
                    if (fail_inc >= cfg.fail_limit)
                    begin
                        rearm         = 1'b1;
                        lock_on_next  = 1'b1;
                        deadline_next = now + NowW'(cfg.lock_window_ms);
                    end
                    else
                    begin
                        lock_on_next = 1'b0;
                    end
                end
                else
                begin
                    out_data_next.verdict = V_OK;
                    miss_cnt_next         = '0;
                    lock_on_next          = 1'b0;
                    last_ok_next          = now;
                    touch                 = 1'b1;
                    fresh_zero            = (idle_ms_reg == '0);
                end
            end
            default:
            begin
                // status poll leaves the state alone
            end
        endcase

        // A rearmed lock has exactly the window left
        if (rearm)
        begin
            out_data_next.lock_left_ms = cfg.lock_window_ms;
        end
        else if (lock_on_next)
        begin
            out_data_next.lock_left_ms = old_left;
        end
        else
        begin
            out_data_next.lock_left_ms = '0;
        end

        out_data_next.idle_expired  = gate_open_next && (touch ? fresh_zero : idle_old);
        out_data_next.persist_fails = (miss_cnt_next >= cfg.fail_limit)
                                      ? cfg.fail_limit : '0;
        out_data_next.gate_is_open  = gate_open_next;
    end

    // Update the gate state and the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_open_reg <= 1'b0;
            held_pin_reg  <= '0;
            idle_ms_reg   <= '0;
            miss_cnt_reg  <= '0;
            lock_on_reg   <= 1'b0;
            deadline_reg  <= '0;
            last_ok_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                gate_open_reg <= gate_open_next;
                held_pin_reg  <= held_pin_next;
                idle_ms_reg   <= idle_ms_next;
                miss_cnt_reg  <= miss_cnt_next;
                lock_on_reg   <= lock_on_next;
                deadline_reg  <= deadline_next;
                last_ok_reg   <= last_ok_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OutDataW'(out_data_reg);

endmodule

`default_nettype wire

>>> hdl/pin_attempt_lockout_gate_core.sv
// Top level of the PIN attempt lockout gate: configuration registers on an
// APB-style port, and the front, queue and back parts. Depends on plag_pkg.
//
// Usage: commands (open, close, verify, status poll) arrive as beats on the
// s_ channel; each gives exactly one result beat on the m_ channel, in order.
// Configuration registers sit at byte address 4*index. The user must write them
// only while no command is in flight; the block itself does not enforce this.
// Pin code, idle budget and restored fail count are sampled at open, fail limit
// and lock window are used live. An accepted beat is written into the queue,
// the back part then registers its result in the output stage, and the
// receiver takes that result beat from there. Throughput: one command per
// cycle while m_tready stays high; the back part finishes each command's state
// update as it registers the result. Backpressure: when m_tready is low the
// result is held in the output register, up to two further commands collect
// in the queue, and then s_tready drops until the receiver takes a beat.
// Reset: rst_n clears the gate state (closed, no pin, no lock), empties the
// queue and the output stage, and loads the register reset values.
`default_nettype none

module pin_attempt_lockout_gate_core
    import plag_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // APB-style configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [AddrW-1:0]    paddr,
    input  wire logic [ApbW-1:0]     pwdata,
    output logic      [ApbW-1:0]     prdata,
    output logic                     pready,
    // Command stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // now_ms[31:0], text_present[32], attempt_char0[40:33], attempt_char1[48:41],
    // attempt_char2[56:49], attempt_char3[64:57], attempt_char4[72:65], zero fill
    input  wire logic [InDataW-1:0]  s_tdata,
    // cmd[1:0]
    input  wire logic [CmdW-1:0]     s_tuser,
    // Result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // verdict[2:0], lock_left_ms[33:3], idle_expired[34], persist_fails[42:35],
    // gate_is_open[43], zero fill
    output logic      [OutDataW-1:0] m_tdata
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;
    logic     q_full, q_empty, q_push, q_pop;
    q_item_t  front_item, head_item;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[AddrW-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_code       <= '0;
            cfg_reg.idle_request_s <= '0;
            cfg_reg.idle_default_s <= IdleW'(300);
            cfg_reg.idle_max_s     <= IdleW'(3600);
            cfg_reg.restored_fails <= '0;
            cfg_reg.fail_limit     <= FailW'(5);
            cfg_reg.lock_window_ms <= WinW'(60000);
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_PIN_CODE:       cfg_reg.pin_code       <= pwdata[PinW-1:0];
                REG_IDLE_REQUEST:   cfg_reg.idle_request_s <= pwdata[IdleW-1:0];
                REG_IDLE_DEFAULT:   cfg_reg.idle_default_s <= pwdata[IdleW-1:0];
                REG_IDLE_MAX:       cfg_reg.idle_max_s     <= pwdata[IdleW-1:0];
                REG_RESTORED_FAILS: cfg_reg.restored_fails <= pwdata[FailW-1:0];
                REG_FAIL_LIMIT:     cfg_reg.fail_limit     <= pwdata[FailW-1:0];
                REG_LOCK_WINDOW:    cfg_reg.lock_window_ms <= pwdata[WinW-1:0];
                default:
                begin
                    // unmapped address, drop the write
                end
            endcase
        end
    end

    // Read back the configuration registers
    always_comb
    begin
        case (reg_idx)
            REG_PIN_CODE:       prdata = ApbW'(cfg_reg.pin_code);
            REG_IDLE_REQUEST:   prdata = ApbW'(cfg_reg.idle_request_s);
            REG_IDLE_DEFAULT:   prdata = ApbW'(cfg_reg.idle_default_s);
            REG_IDLE_MAX:       prdata = ApbW'(cfg_reg.idle_max_s);
            REG_RESTORED_FAILS: prdata = ApbW'(cfg_reg.restored_fails);
            REG_FAIL_LIMIT:     prdata = ApbW'(cfg_reg.fail_limit);
            REG_LOCK_WINDOW:    prdata = ApbW'(cfg_reg.lock_window_ms);
            default:            prdata = '0;
        endcase
    end

    plag_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (front_item)
    );

    plag_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (front_item),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .item_out (head_item)
    );

    plag_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
